/* hw/rtl/c3f_pkg.sv */
// shared types and constants of the 3x3 convolution filter
// used by the filter top level and its cells; depends on nothing
package c3f_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int COEF_BITS_DEF = 8;
    localparam int PIX_W         = 8;
    localparam int POS_W         = 10;
    localparam int CFG_W         = 24;
    localparam int DIV_W         = 8;
    localparam int REM_W         = 16;
    localparam int QUO_W         = 8;
    localparam int HGT_W         = 11;
    localparam int MAX_HEIGHT    = 1024;
    localparam int OUT_TDATA_W   = 32;

    typedef enum logic [2:0] {
        REG_COEF_ROW0 = 3'd0,
        REG_COEF_ROW1 = 3'd1,
        REG_COEF_ROW2 = 3'd2,
        REG_DIVISOR   = 3'd3,
        REG_WIDTH     = 3'd4,
        REG_HEIGHT    = 3'd5
    } cfg_reg_t;

    // index 0 is the row two above, 2 is the incoming sample
    typedef logic [2:0][PIX_W-1:0] pix_col_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } meta_t;

    typedef struct packed {
        meta_t            meta;
        logic             sat;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_word_t;

endpackage

/* hw/rtl/c3f_col_cell.sv */
// one window column cell: holds three samples, passes them left, and
// registers the column's weighted sum; uses c3f_pkg
module c3f_col_cell
    import c3f_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          shift,
    input  pix_col_t                      col_in,
    input  logic [2:0][COEF_BITS-1:0]     taps,
    output pix_col_t                      col_out,
    output logic signed [COEF_BITS+10:0]  partial
);

    localparam int PROD_W = COEF_BITS + 9;
    localparam int COL_W  = PROD_W + 2;

    pix_col_t                 col_reg;
    logic signed [COL_W-1:0]  partial_reg;
    logic signed [COL_W-1:0]  partial_next;
    logic signed [PROD_W-1:0] prod [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i] = $signed({1'b0, col_reg[i]}) * $signed(taps[i]);
        end
        partial_next = COL_W'(prod[0]) + COL_W'(prod[1]) + COL_W'(prod[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift) begin
            col_reg <= col_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            partial_reg <= partial_next;
        end
    end

    assign col_out = col_reg;
    assign partial = partial_reg;

endmodule

/* hw/rtl/c3f_div_cell.sv */
// one quotient bit of the restoring divider chain
// uses c3f_pkg for the word passed between cells
module c3f_div_cell
    import c3f_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [DIV_W-1:0] divisor,
    input  div_word_t        word_in,
    output div_word_t        word_out
);

    div_word_t        word_reg;
    div_word_t        word_next;
    logic [REM_W-1:0] dshift;

    always_comb begin
        dshift    = {{(REM_W-DIV_W){1'b0}}, divisor} << BIT;
        word_next = word_in;
        if (word_in.rem >= dshift) begin
            word_next.rem      = word_in.rem - dshift;
            word_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
        end else if (en) begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

/* hw/rtl/conv3x3_image_filter.sv */
// channel   dir  ports                       word
// s_        in   s_tvalid s_tready s_tdata    [7:0] sample; s_tuser = frame_start
// m_        out  m_tvalid m_tready m_tdata    [7:0] filtered [17:8] row [27:18] col
//                m_tlast                      last interior pixel of the plane
// cfg       in   cfg_wr_en cfg_index cfg_wdata
//
// one sample per cycle while the output is not stalled; a result passes the
// line store read, window shift, column products, sum, range check, 8 divider
// cells and the output register. the whole pipeline advances together, so it
// holds while a result word waits on m_tready. reset clears counters and valids;
// line stores are not cleared. top level of the filter, uses c3f_pkg and cells
module conv3x3_image_filter
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIX_W-1:0]       s_tdata,   // [7:0] sample
    input  logic                   s_tuser,   // [0] frame_start
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] filtered [17:8] out_row [27:18] out_col
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int SZ_W   = (WW > HGT_W) ? WW : HGT_W;
    localparam int COL_W  = COEF_BITS + 11;
    localparam int SUM_W  = COL_W + 2;
    localparam int CMP_W  = (SUM_W > 17) ? SUM_W : 17;
    localparam int EXT_W  = 3 * COEF_BITS + CFG_W;

    // configuration
    logic [CFG_W-1:0] coef_reg [3];
    logic [DIV_W-1:0] divisor_reg;
    logic [HGT_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= '0;
            coef_reg[1] <= CFG_W'(256);
            coef_reg[2] <= '0;
            divisor_reg <= DIV_W'(1);
            width_reg   <= HGT_W'(1024);
            height_reg  <= HGT_W'(1024);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COEF_ROW0: coef_reg[0] <= cfg_wdata;
                REG_COEF_ROW1: coef_reg[1] <= cfg_wdata;
                REG_COEF_ROW2: coef_reg[2] <= cfg_wdata;
                REG_DIVISOR:   divisor_reg <= cfg_wdata[DIV_W-1:0];
                REG_WIDTH:     width_reg   <= cfg_wdata[HGT_W-1:0];
                REG_HEIGHT:    height_reg  <= cfg_wdata[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    logic             en;
    logic             accept;
    logic [SZ_W-1:0]  w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [DIV_W-1:0] d_eff;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    always_comb begin
        w_eff = SZ_W'(width_reg);
        if (w_eff < SZ_W'(3)) begin
            w_eff = SZ_W'(3);
        end else if (w_eff > SZ_W'(MAX_WIDTH)) begin
            w_eff = SZ_W'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (h_eff < HGT_W'(3)) begin
            h_eff = HGT_W'(3);
        end else if (h_eff > HGT_W'(MAX_HEIGHT)) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end
        d_eff = (divisor_reg > DIV_W'(1)) ? divisor_reg : DIV_W'(1);
    end

    // raster position
    logic [POS_W-1:0]  row_reg, row_next, row_cur;
    logic [ADDR_W-1:0] col_reg, col_next, col_cur;
    logic [SZ_W-1:0]   col_ext, col_inc;
    logic [HGT_W-1:0]  row_ext, row_inc;
    logic              emit, last;
    logic [ADDR_W+POS_W-1:0] col_m1;
    meta_t             meta0;

    always_comb begin
        row_cur = s_tuser ? '0 : row_reg;
        col_cur = s_tuser ? '0 : col_reg;
        col_ext = SZ_W'(col_cur);
        row_ext = HGT_W'(row_cur);
        col_inc = col_ext + SZ_W'(1);
        row_inc = row_ext + HGT_W'(1);
        emit = (row_ext >= HGT_W'(2)) && (col_ext >= SZ_W'(2))
            && (row_ext < h_eff) && (col_ext < w_eff);
        last = (row_ext == h_eff - HGT_W'(1)) && (col_ext == w_eff - SZ_W'(1));
        col_next = ADDR_W'(col_inc);
        row_next = row_cur;
        if (col_inc >= w_eff) begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : POS_W'(row_inc);
        end else if (row_ext >= h_eff) begin
            row_next = '0;
        end
        col_m1      = (ADDR_W + POS_W)'(ADDR_W'(col_cur - ADDR_W'(1)));
        meta0.valid = emit;
        meta0.row   = row_cur - POS_W'(1);
        meta0.col   = col_m1[POS_W-1:0];
        meta0.last  = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // stage 1: line store read
    logic              v1_reg;
    meta_t             meta1_reg, meta2_reg, meta3_reg, meta4_reg;
    logic [PIX_W-1:0]  sample1_reg;
    logic [ADDR_W-1:0] addr1_reg;
    logic [PIX_W-1:0]  above_rd_reg, two_rd_reg;
    logic [PIX_W-1:0]  above_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  two_mem   [MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            above_rd_reg <= above_mem[col_cur];
            if (v1_reg) begin
                above_mem[addr1_reg] <= sample1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            two_rd_reg <= two_mem[col_cur];
            if (v1_reg) begin
                two_mem[addr1_reg] <= above_rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sample1_reg <= s_tdata;
            addr1_reg   <= col_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            meta1_reg <= '0;
            meta2_reg <= '0;
            meta3_reg <= '0;
        end else if (en) begin
            v1_reg    <= accept;
            meta1_reg <= accept ? meta0 : '0;
            meta2_reg <= meta1_reg;
            meta3_reg <= meta2_reg;
        end
    end

    // window cells, right cell takes the fresh column
    logic [EXT_W-1:0]              coef_ext [3];
    logic [2:0][COEF_BITS-1:0]     cell_taps [3];
    pix_col_t                      cell_in [3];
    pix_col_t                      cell_out [3];
    logic signed [COL_W-1:0]       cell_part [3];

    assign cell_in[2] = {sample1_reg, above_rd_reg, two_rd_reg};

    for (genvar k = 0; k < 3; k++) begin : g_cell
        for (genvar i = 0; i < 3; i++) begin : g_tap
            assign cell_taps[k][i] = coef_ext[i][(2-k)*COEF_BITS +: COEF_BITS];
        end
        assign coef_ext[k] = EXT_W'(coef_reg[k]);
        if (k < 2) begin : g_link
            assign cell_in[k] = cell_out[k+1];
        end
        c3f_col_cell #(
            .COEF_BITS (COEF_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .shift   (en && v1_reg),
            .col_in  (cell_in[k]),
            .taps    (cell_taps[k]),
            .col_out (cell_out[k]),
            .partial (cell_part[k])
        );
    end

    // stage 4: window sum
    logic signed [SUM_W-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= SUM_W'(cell_part[0]) + SUM_W'(cell_part[1]) + SUM_W'(cell_part[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta4_reg <= '0;
        end else if (en) begin
            meta4_reg <= meta3_reg;
        end
    end

    // stage 5: negative sums go to zero, quotients past 255 saturate
    div_word_t        div_word [9];
    div_word_t        div5_reg, div5_next;
    logic [CMP_W-1:0] sum_ext, lim;

    always_comb begin
        sum_ext        = CMP_W'(sum_reg);
        lim            = CMP_W'({d_eff, 8'b0});
        div5_next      = '0;
        div5_next.meta = meta4_reg;
        if (!sum_reg[SUM_W-1]) begin
            if (sum_ext >= lim) begin
                div5_next.sat = 1'b1;
            end else begin
                div5_next.rem = sum_ext[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div5_reg <= '0;
        end else if (en) begin
            div5_reg <= div5_next;
        end
    end

    assign div_word[0] = div5_reg;

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        c3f_div_cell #(
            .BIT (QUO_W - 1 - j)
        ) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .divisor  (d_eff),
            .word_in  (div_word[j]),
            .word_out (div_word[j+1])
        );
    end

    // output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tlast_reg;
    div_word_t              dfin;

    assign dfin = div_word[QUO_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dfin.meta.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {4'b0, dfin.meta.col, dfin.meta.row,
                            dfin.sat ? 8'hFF : dfin.quo};
            m_tlast_reg <= dfin.meta.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* hw/rtl/c3f_checker.sv */
// port-level checks of the filter and their bind to the top level
// depends on conv3x3_image_filter port names
module c3f_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a held result word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // input side only moves when the output can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stall");

    // results are interior pixels, pad bits zero
    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:28] == 4'd0 && m_tdata[17:8] != 10'd0
            && m_tdata[27:18] != 10'd0)
        else $error("border pixel or dirty pad bits in result");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind conv3x3_image_filter c3f_checker u_c3f_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
